// ----- hdl/ppsh_pkg.sv -----
// ppsh_pkg: shared types, register and curve codes, and the sine table builder
// for the particle projection and shading block. No dependencies.
package ppsh_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_CURRENT_TIME  = 3'd0;
  localparam logic [2:0] CFG_FOCAL_LENGTH  = 3'd1;
  localparam logic [2:0] CFG_CENTER_X      = 3'd2;
  localparam logic [2:0] CFG_CENTER_Y      = 3'd3;
  localparam logic [2:0] CFG_SIZE_CURVE    = 3'd4;
  localparam logic [2:0] CFG_OPACITY_CURVE = 3'd5;
  localparam logic [2:0] CFG_PARTICLE_KIND = 3'd6;

  // life curve codes
  localparam logic [2:0] CURVE_CONST    = 3'd0;
  localparam logic [2:0] CURVE_FADE_IN  = 3'd1;
  localparam logic [2:0] CURVE_FADE_OUT = 3'd2;
  localparam logic [2:0] CURVE_SINE     = 3'd3;
  localparam logic [2:0] CURVE_BELL     = 3'd4;

  localparam logic [16:0] ONE_Q16       = 17'd65536;
  localparam logic [48:0] SIZE_MIN_Q24  = 49'd838860;
  localparam logic [31:0] RADIUS_MIN_Q8 = 32'd64;
  localparam logic [63:0] PI_Q60        = 64'h3243F6A8885A308D;

  // quotient bits of the back-end dividers; offsets beyond this saturate anyway
  localparam int DIV_QW = 34;

  typedef struct packed {
    logic [31:0] current_time;
    logic [31:0] focal_length;
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [2:0]  size_curve;
    logic [2:0]  opacity_curve;
    logic [3:0]  particle_kind;
  } cfg_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] birth_time;
    logic [31:0] lifetime;
    logic [31:0] base_size;
    logic [23:0] birth_rgb;
    logic [23:0] death_rgb;
    logic [15:0] opacity_scale;
  } part_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [23:0] birth_rgb;
    logic [23:0] death_rgb;
    logic [16:0] f;
    logic [48:0] size24;
    logic [32:0] opa;
  } shade_t;

  // one request between front, queue and back
  typedef struct packed {
    logic   vld;
    shade_t data;
  } shade_req_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] screen_x;
    logic [31:0] screen_y;
    logic [31:0] radius;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [3:0]  kind_tag;
    logic [31:0] depth;
  } res_t;

  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // long division used only while building the table at elaboration
  function automatic logic [63:0] div_u64(logic [63:0] n, logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // sin(pi*i/2^bits) in Q1.16 via a Q60 Taylor series, evaluated at elaboration
  function automatic logic [16:0] sine_entry(int unsigned bits, int unsigned i);
    logic [63:0] n;
    logic [63:0] j;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] dv;
    n = 64'd1 << bits;
    j = (64'(i) <= (n >> 1)) ? 64'(i) : n - 64'(i);
    x = (PI_Q60 >> bits) * j + (((PI_Q60 & (n - 64'd1)) * j) >> bits);
    x2 = mul_q60(x, x);
    term = x;
    sum = x;
    for (int k = 1; k <= 20; k++) begin
      if (term != 64'd0) begin
        dv = 64'(2 * k) * 64'(2 * k + 1);
        term = div_u64(mul_q60(term, x2), dv);
        if ((k & 1) != 0) sum = (sum >= term) ? sum - term : 64'd0;
        else sum = sum + term;
      end
    end
    sum = (sum + (64'd1 << 43)) >> 44;
    return sum[16:0];
  endfunction

endpackage

// ----- hdl/ppsh_div.sv -----
// ppsh_div: pipelined restoring divider, one quotient bit per stage.
// Quotient saturation flag when the result needs more than QW bits. Uses no package.
module ppsh_div #(
  parameter int NW = 64,
  parameter int DW = 33,
  parameter int QW = 34
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          sat
);

  localparam int HW = NW - QW;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [DW-1:0] d_r   [QW];
  logic [QW-1:0] q_r   [QW+1];
  logic          sat_r [QW+1];

  logic [CW-1:0] hi_ext;
  logic [CW-1:0] den_ext;

  assign hi_ext  = CW'(num[NW-1:QW]);
  assign den_ext = CW'(den);

  always_ff @(posedge clk) begin
    rem_r[0] <= hi_ext[DW-1:0];
    low_r[0] <= num[QW-1:0];
    d_r[0]   <= den;
    q_r[0]   <= '0;
    sat_r[0] <= hi_ext >= den_ext;
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [DW:0] t;
    logic        ge;
    assign t  = {rem_r[k-1], low_r[k-1][QW-1]};
    assign ge = t >= {1'b0, d_r[k-1]};
    always_ff @(posedge clk) begin
      q_r[k]   <= {q_r[k-1][QW-2:0], ge};
      sat_r[k] <= sat_r[k-1];
    end
    if (k < QW) begin : g_carry
      logic [DW:0] diff;
      assign diff = t - {1'b0, d_r[k-1]};
      always_ff @(posedge clk) begin
        rem_r[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
        low_r[k] <= {low_r[k-1][QW-2:0], 1'b0};
        d_r[k]   <= d_r[k-1];
      end
    end
  end

  assign quo = q_r[QW];
  assign sat = sat_r[QW];

endmodule

// ----- hdl/ppsh_front.sv -----
// ppsh_front: takes particles, culls by age, works out the life fraction,
// applies the size and opacity curves. Depends on ppsh_pkg and ppsh_div.
module ppsh_front #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  ppsh_pkg::part_t        part,
  input  ppsh_pkg::cfg_t         cfg,
  output ppsh_pkg::shade_req_t   req
);
  import ppsh_pkg::*;

  localparam int S     = 16 - SINE_TABLE_BITS;
  localparam int SN    = 1 << SINE_TABLE_BITS;
  localparam int F_LAT = 17;

  typedef logic [16:0] sine_tab_t [SN+1];

  function automatic sine_tab_t build_sine();
    sine_tab_t t;
    for (int i = 0; i <= SN; i++) t[i] = sine_entry(SINE_TABLE_BITS, i);
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  function automatic logic [16:0] curve(logic [2:0] mode, logic [16:0] f,
                                        logic [16:0] ta, logic [16:0] tb);
    logic [16:0]   inv;
    logic [S:0]    w1;
    logic [S:0]    w2;
    logic [17+S:0] mix;
    logic [33:0]   bell;
    logic [16:0]   m;
    inv  = ONE_Q16 - f;
    w2   = {1'b0, f[S-1:0]};
    w1   = {1'b1, {S{1'b0}}} - w2;
    mix  = (18+S)'(ta) * (18+S)'(w1) + (18+S)'(tb) * (18+S)'(w2);
    bell = {17'd0, f} * {17'd0, inv};
    case (mode)
      CURVE_FADE_IN:  m = f;
      CURVE_FADE_OUT: m = inv;
      CURVE_SINE:     m = mix[16+S:S];
      CURVE_BELL:     m = bell[30:14];
      default:        m = ONE_Q16;
    endcase
    return m;
  endfunction

  // stage A: registered request
  logic        a_v_r;
  part_t       a_part_r;
  logic [31:0] age;
  logic        kill_a;
  logic        full_a;

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else a_v_r <= accept;
    a_part_r <= part;
  end

  assign age    = cfg.current_time - a_part_r.birth_time;
  assign kill_a = (cfg.current_time == 32'd0) ||
                  (a_part_r.birth_time > cfg.current_time) ||
                  (age > a_part_r.lifetime);
  assign full_a = age >= a_part_r.lifetime;

  // life fraction divider and its side line
  logic [15:0] fq;
  logic        fsat;

  ppsh_div #(.NW(48), .DW(32), .QW(16)) u_fdiv (
    .clk (clk),
    .num ({age, 16'd0}),
    .den (a_part_r.lifetime),
    .quo (fq),
    .sat (fsat)
  );

  logic  dl_v_r    [F_LAT];
  logic  dl_full_r [F_LAT];
  part_t dl_part_r [F_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < F_LAT; k++) dl_v_r[k] <= 1'b0;
    end else begin
      dl_v_r[0] <= a_v_r && !kill_a;
      for (int k = 1; k < F_LAT; k++) dl_v_r[k] <= dl_v_r[k-1];
    end
    dl_full_r[0] <= full_a;
    dl_part_r[0] <= a_part_r;
    for (int k = 1; k < F_LAT; k++) begin
      dl_full_r[k] <= dl_full_r[k-1];
      dl_part_r[k] <= dl_part_r[k-1];
    end
  end

  // stage D: fraction ready, sine table lookup
  logic [16:0]              f_d;
  logic [SINE_TABLE_BITS:0] idx;
  logic [SINE_TABLE_BITS:0] idx1;

  // the divider saturates only where age >= lifetime, the case full already forces to one
  assign f_d  = (dl_full_r[F_LAT-1] || fsat) ? ONE_Q16 : {1'b0, fq};
  assign idx  = f_d[16:S];
  assign idx1 = (idx == (SINE_TABLE_BITS+1)'(SN)) ? idx : idx + 1'b1;

  logic        c1_v_r;
  part_t       c1_part_r;
  logic [16:0] c1_f_r;
  logic [16:0] rom_a_r;
  logic [16:0] rom_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c1_v_r <= 1'b0;
    else c1_v_r <= dl_v_r[F_LAT-1];
    c1_part_r <= dl_part_r[F_LAT-1];
    c1_f_r    <= f_d;
    rom_a_r   <= SINE_TAB[idx];
    rom_b_r   <= SINE_TAB[idx1];
  end

  // stage C2: curve multipliers
  logic        c2_v_r;
  part_t       c2_part_r;
  logic [16:0] c2_f_r;
  logic [16:0] m_s_r;
  logic [16:0] m_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c2_v_r <= 1'b0;
    else c2_v_r <= c1_v_r;
    c2_part_r <= c1_part_r;
    c2_f_r    <= c1_f_r;
    m_s_r     <= curve(cfg.size_curve, c1_f_r, rom_a_r, rom_b_r);
    m_o_r     <= curve(cfg.opacity_curve, c1_f_r, rom_a_r, rom_b_r);
  end

  // stage C3: scaled size and opacity
  logic   c3_v_r;
  shade_t c3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c3_v_r <= 1'b0;
    else c3_v_r <= c2_v_r;
    c3_r.pos_x     <= c2_part_r.pos_x;
    c3_r.pos_y     <= c2_part_r.pos_y;
    c3_r.pos_z     <= c2_part_r.pos_z;
    c3_r.birth_rgb <= c2_part_r.birth_rgb;
    c3_r.death_rgb <= c2_part_r.death_rgb;
    c3_r.f         <= c2_f_r;
    c3_r.size24    <= {17'd0, c2_part_r.base_size} * {32'd0, m_s_r};
    c3_r.opa       <= {17'd0, c2_part_r.opacity_scale} * {16'd0, m_o_r};
  end

  assign req.vld  = c3_v_r && (c3_r.size24 > SIZE_MIN_Q24) && (c3_r.opa != 33'd0);
  assign req.data = c3_r;

endmodule

// ----- hdl/ppsh_queue.sv -----
// ppsh_queue: short FIFO between the front and back ends, registered read port.
// Depends on ppsh_pkg for the request type.
module ppsh_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ppsh_pkg::shade_req_t wr,
  output logic                 full,
  output ppsh_pkg::shade_req_t rd
);
  import ppsh_pkg::*;

  localparam int QDEPTH = 4;
  localparam int AW     = $clog2(QDEPTH);

  shade_t      mem_r [QDEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          push;
  logic          pop;
  logic          rd_vld_r;
  shade_t        rd_data_r;

  assign full    = cnt_r == (AW+1)'(QDEPTH);
  assign push    = wr.vld && !full;
  assign pop     = cnt_r != '0;  // back end never stalls
  assign wp_nxt  = push ? wp_r + 1'b1 : wp_r;
  assign rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
  assign cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      rp_r     <= '0;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= pop;
    end
    if (push) mem_r[wp_r] <= wr.data;
    rd_data_r <= mem_r[rp_r];
  end

  assign rd.vld  = rd_vld_r;
  assign rd.data = rd_data_r;

endmodule

// ----- hdl/ppsh_back.sv -----
// ppsh_back: depth cull, perspective divide, radius cull, colour and alpha.
// Depends on ppsh_pkg and ppsh_div.
module ppsh_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ppsh_pkg::shade_req_t rd,
  input  ppsh_pkg::cfg_t       cfg,
  output ppsh_pkg::res_t       res
);
  import ppsh_pkg::*;

  localparam int DLAT = DIV_QW + 1;

  typedef struct packed {
    logic        negx;
    logic        negy;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [31:0] depth;
  } side_t;

  function automatic logic [7:0] lerp8(logic [7:0] a, logic [7:0] b, logic [16:0] f);
    logic [25:0] s;
    s = 26'(a) * 26'(ONE_Q16 - f) + 26'(b) * 26'(f) + 26'd32768;
    return s[23:16];
  endfunction

  function automatic logic [31:0] place(logic [31:0] c, logic neg,
                                        logic [DIV_QW-1:0] q, logic sat);
    logic [DIV_QW:0]       off;
    logic signed [DIV_QW+2:0] o;
    logic signed [DIV_QW+2:0] r;
    logic [31:0]           p;
    off = sat ? {1'b1, {DIV_QW{1'b0}}} : {1'b0, q};
    o   = $signed({2'b00, off});
    r   = (DIV_QW+3)'($signed(c)) + (neg ? -o : o);
    if (r > (DIV_QW+3)'(64'sd2147483647)) p = 32'h7FFFFFFF;
    else if (r < (DIV_QW+3)'(-64'sd2147483648)) p = 32'h80000000;
    else p = r[31:0];
    return p;
  endfunction

  // B0: popped request
  logic   b0_v_r;
  shade_t b0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b0_v_r <= 1'b0;
    else b0_v_r <= rd.vld;
    b0_r <= rd.data;
  end

  logic signed [33:0] denom;
  logic               kill_d;
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic [32:0]        magx;
  logic [32:0]        magy;
  logic [24:0]        a_cl;
  logic [32:0]        a_sc;

  assign denom  = $signed({2'b00, cfg.focal_length}) + 34'($signed(b0_r.pos_z));
  assign kill_d = denom <= 34'sd256;
  assign dx     = 33'($signed(b0_r.pos_x)) - 33'($signed(cfg.center_x));
  assign dy     = 33'($signed(b0_r.pos_y)) - 33'($signed(cfg.center_y));
  assign magx   = dx[32] ? 33'(-dx) : 33'(dx);
  assign magy   = dy[32] ? 33'(-dy) : 33'(dy);
  assign a_cl   = (b0_r.opa > 33'h1000000) ? 25'h1000000 : b0_r.opa[24:0];
  assign a_sc   = {a_cl, 8'd0} - 33'(a_cl) + 33'h800000;

  // B1: partial products and shading
  logic        b1_v_r;
  logic [32:0] b1_d_r;
  logic [63:0] prl_r;
  logic [48:0] prh_r;
  logic [63:0] pxp_r;
  logic [63:0] pyp_r;
  side_t       b1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b1_v_r <= 1'b0;
    else b1_v_r <= b0_v_r && !kill_d;
    b1_d_r          <= denom[32:0];
    prl_r           <= {32'd0, b0_r.size24[31:0]} * {32'd0, cfg.focal_length};
    prh_r           <= {32'd0, b0_r.size24[48:32]} * {17'd0, cfg.focal_length};
    pxp_r           <= {32'd0, magx[31:0]} * {32'd0, cfg.focal_length};
    pyp_r           <= {32'd0, magy[31:0]} * {32'd0, cfg.focal_length};
    b1_side_r.negx  <= dx[32];
    b1_side_r.negy  <= dy[32];
    b1_side_r.red   <= lerp8(b0_r.birth_rgb[23:16], b0_r.death_rgb[23:16], b0_r.f);
    b1_side_r.green <= lerp8(b0_r.birth_rgb[15:8], b0_r.death_rgb[15:8], b0_r.f);
    b1_side_r.blue  <= lerp8(b0_r.birth_rgb[7:0], b0_r.death_rgb[7:0], b0_r.f);
    b1_side_r.alpha <= a_sc[31:24];
    b1_side_r.depth <= b0_r.pos_z;
  end

  logic [80:0] prad;
  assign prad = 81'(prl_r) + (81'(prh_r) << 32);

  // radius = size*focal/(D*2^17) goes as floor(floor(P/2^17)/D)
  logic [DIV_QW-1:0] rq, xq, yq;
  logic              rs, xs, ys;

  ppsh_div #(.NW(64), .DW(33), .QW(DIV_QW)) u_rdiv (
    .clk (clk), .num (prad[80:17]), .den (b1_d_r), .quo (rq), .sat (rs)
  );
  ppsh_div #(.NW(64), .DW(33), .QW(DIV_QW)) u_xdiv (
    .clk (clk), .num (pxp_r), .den (b1_d_r), .quo (xq), .sat (xs)
  );
  ppsh_div #(.NW(64), .DW(33), .QW(DIV_QW)) u_ydiv (
    .clk (clk), .num (pyp_r), .den (b1_d_r), .quo (yq), .sat (ys)
  );

  logic  sv_r [DLAT];
  side_t sd_r [DLAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DLAT; k++) sv_r[k] <= 1'b0;
    end else begin
      sv_r[0] <= b1_v_r;
      for (int k = 1; k < DLAT; k++) sv_r[k] <= sv_r[k-1];
    end
    sd_r[0] <= b1_side_r;
    for (int k = 1; k < DLAT; k++) sd_r[k] <= sd_r[k-1];
  end

  // E: radius cull and screen placement
  logic        radsat;
  logic [31:0] rad;
  logic        rad_ok;
  side_t       se;

  assign se     = sd_r[DLAT-1];
  assign radsat = rs || (rq[DIV_QW-1:32] != '0);
  assign rad    = radsat ? 32'hFFFFFFFF : rq[31:0];
  assign rad_ok = radsat || (rq[31:0] >= RADIUS_MIN_Q8);

  always_ff @(posedge clk) begin
    if (!rst_n) res.vld <= 1'b0;
    else res.vld <= sv_r[DLAT-1] && rad_ok;
    res.screen_x <= place(cfg.center_x, se.negx, xq, xs);
    res.screen_y <= place(cfg.center_y, se.negy, yq, ys);
    res.radius   <= rad;
    res.red      <= se.red;
    res.green    <= se.green;
    res.blue     <= se.blue;
    res.alpha    <= se.alpha;
    res.kind_tag <= cfg.particle_kind;
    res.depth    <= se.depth;
  end

endmodule

// ----- hdl/particle_project_and_shade.sv -----
// particle_project_and_shade: top level with configuration registers,
// front end, request queue and back end. Depends on ppsh_pkg and all ppsh_ modules.
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  in_     | start, busy            | pos, times, size, colours, opacity scale
//  out_    | out_valid (one cycle)  | screen x/y, radius, rgba, kind, depth
//  cfg_    | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// One particle per clock while busy is low; the result strobe follows the accepting
// edge through the input register, life divider, curve stages, queue write and read,
// back stages, projection dividers and output register.
// Synchronous active-low reset sets config registers to defaults and clears all valid bits.
// busy rises only if the queue fills; the back end drains it every cycle.
// Results cannot be held off; culled particles give no strobe.
module particle_project_and_shade #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [31:0] in_birth_time,
  input  logic [31:0] in_lifetime,
  input  logic [31:0] in_base_size,
  input  logic [23:0] in_birth_rgb,
  input  logic [23:0] in_death_rgb,
  input  logic [15:0] in_opacity_scale,
  output logic        out_valid,
  output logic [31:0] out_screen_x,
  output logic [31:0] out_screen_y,
  output logic [31:0] out_radius,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [3:0]  out_kind_tag,
  output logic [31:0] out_depth,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ppsh_pkg::*;

  cfg_t       cfg_r;
  part_t      part;
  shade_req_t f_req;
  shade_req_t q_req;
  res_t       res;
  logic       q_full;
  logic       accept;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.current_time  <= 32'd0;
      cfg_r.focal_length  <= 32'd256000;
      cfg_r.center_x      <= 32'd0;
      cfg_r.center_y      <= 32'd0;
      cfg_r.size_curve    <= CURVE_CONST;
      cfg_r.opacity_curve <= CURVE_CONST;
      cfg_r.particle_kind <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CURRENT_TIME:  cfg_r.current_time  <= cfg_data;
        CFG_FOCAL_LENGTH:  cfg_r.focal_length  <= cfg_data;
        CFG_CENTER_X:      cfg_r.center_x      <= cfg_data;
        CFG_CENTER_Y:      cfg_r.center_y      <= cfg_data;
        CFG_SIZE_CURVE:    cfg_r.size_curve    <= cfg_data[2:0];
        CFG_OPACITY_CURVE: cfg_r.opacity_curve <= cfg_data[2:0];
        CFG_PARTICLE_KIND: cfg_r.particle_kind <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign part.pos_x         = in_pos_x;
  assign part.pos_y         = in_pos_y;
  assign part.pos_z         = in_pos_z;
  assign part.birth_time    = in_birth_time;
  assign part.lifetime      = in_lifetime;
  assign part.base_size     = in_base_size;
  assign part.birth_rgb     = in_birth_rgb;
  assign part.death_rgb     = in_death_rgb;
  assign part.opacity_scale = in_opacity_scale;

  ppsh_front #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .part   (part),
    .cfg    (cfg_r),
    .req    (f_req)
  );

  ppsh_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (f_req),
    .full  (q_full),
    .rd    (q_req)
  );

  ppsh_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .rd    (q_req),
    .cfg   (cfg_r),
    .res   (res)
  );

  assign out_valid    = res.vld;
  assign out_screen_x = res.screen_x;
  assign out_screen_y = res.screen_y;
  assign out_radius   = res.radius;
  assign out_red      = res.red;
  assign out_green    = res.green;
  assign out_blue     = res.blue;
  assign out_alpha    = res.alpha;
  assign out_kind_tag = res.kind_tag;
  assign out_depth    = res.depth;

  // the front end cannot stall, so a request must never meet a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(f_req.vld && q_full))
    else $error("request pushed into full queue");

  // radius cull holds on every delivered sprite
  a_radius_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_radius >= RADIUS_MIN_Q8))
    else $error("sprite delivered below minimum radius");

  // the queue never stays full
  a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |=> !q_full)
    else $error("queue stayed full");

endmodule
